@@ src/rfc_pkg.sv @@
// reader frame codec package: shared types, character codes and digit helpers
// used by the controller, the datapath and the top level
package rfc_pkg;

  // fixed field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned AddrW    = 7;
  localparam int unsigned KindW    = 2;
  localparam int unsigned StatW    = 2;
  localparam int unsigned PayCntW  = 7;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned StepW    = 4;

  // result kinds
  localparam logic [KindW-1:0] KIND_FRAME  = 2'd0;
  localparam logic [KindW-1:0] KIND_PAY    = 2'd1;
  localparam logic [KindW-1:0] KIND_STATUS = 2'd2;

  // reply status codes
  localparam logic [StatW-1:0] ST_OK       = 2'd0;
  localparam logic [StatW-1:0] ST_SHORT    = 2'd1;
  localparam logic [StatW-1:0] ST_BAD_SUM  = 2'd2;
  localparam logic [StatW-1:0] ST_OVERFLOW = 2'd3;

  // command codes
  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_RECV = 1'b1;

  // frame characters
  localparam logic [ByteW-1:0] CH_SOH    = 8'h01;
  localparam logic [ByteW-1:0] CH_STX    = 8'h02;
  localparam logic [ByteW-1:0] CH_ETX    = 8'h03;
  localparam logic [ByteW-1:0] CH_S      = 8'h53;
  localparam logic [ByteW-1:0] CH_ZERO   = 8'h30;
  localparam logic [ByteW-1:0] SUM_MARK  = 8'h20;
  localparam logic [ByteW-1:0] FUNC_RAW  = 8'hFF;

  // frame step indexes
  localparam logic [StepW-1:0] STEP_SOH  = 4'd0;
  localparam logic [StepW-1:0] STEP_S    = 4'd1;
  localparam logic [StepW-1:0] STEP_AT   = 4'd2;
  localparam logic [StepW-1:0] STEP_AO   = 4'd3;
  localparam logic [StepW-1:0] STEP_FH   = 4'd4;
  localparam logic [StepW-1:0] STEP_FL   = 4'd5;
  localparam logic [StepW-1:0] STEP_STX  = 4'd6;
  localparam logic [StepW-1:0] STEP_D0   = 4'd7;
  localparam logic [StepW-1:0] STEP_D1   = 4'd8;
  localparam logic [StepW-1:0] STEP_D2   = 4'd9;

  // first payload index in a reply
  localparam int unsigned PayFirst = 7;
  localparam int unsigned PayOver  = 9;

  typedef struct packed {
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } dec_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic emit_frame;
    logic pay_start;
    logic rd_req;
    logic emit_pay;
    logic emit_stat;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic frame_last;
    logic has_pay;
    logic pay_last;
  } sts_t;

  // three decimal digits of a byte; tens by reciprocal multiply
  function automatic dec_t dec3(input logic [7:0] v);
    dec_t        d;
    logic [7:0]  r;
    logic [15:0] p;
    logic [7:0]  t10;
    if (v >= 8'd200) begin
      d.hund = 4'd2;
      r      = v - 8'd200;
    end else if (v >= 8'd100) begin
      d.hund = 4'd1;
      r      = v - 8'd100;
    end else begin
      d.hund = 4'd0;
      r      = v;
    end
    p      = {8'd0, r} * 16'd205;
    d.tens = 4'(p >> 11);
    t10    = {4'd0, d.tens} * 8'd10;
    d.ones = 4'(r - t10);
    return d;
  endfunction

  // uppercase hex character
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) c = CH_ZERO + {4'd0, v};
    else           c = 8'h37 + {4'd0, v};
    return c;
  endfunction

endpackage

@@ src/rfc_ctrl.sv @@
// reader frame codec controller: sequences frame emission, payload readout
// and status; depends on rfc_pkg for the command and status structs
module rfc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_cmd_i,
  input  logic          in_final_i,
  input  rfc_pkg::sts_t sts_i,
  output rfc_pkg::cmd_t cmd_o,
  output logic          in_ready_o
);
  import rfc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SEND, S_CHECK, S_RREQ, S_RDAT, S_STAT
  } state_e;

  state_e state_q, state_d;

  // command decode from state
  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (in_cmd_i == CMD_SEND) state_d = S_SEND;
          else if (in_final_i)      state_d = S_CHECK;
        end
      end
      S_SEND: begin
        if (sts_i.out_free) begin
          cmd_o.emit_frame = 1'b1;
          if (sts_i.frame_last) state_d = S_IDLE;
        end
      end
      S_CHECK: begin
        cmd_o.pay_start = 1'b1;
        state_d = sts_i.has_pay ? S_RREQ : S_STAT;
      end
      S_RREQ: begin
        cmd_o.rd_req = 1'b1;
        state_d = S_RDAT;
      end
      S_RDAT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_pay = 1'b1;
          state_d = sts_i.pay_last ? S_STAT : S_RREQ;
        end
      end
      S_STAT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_stat = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/rfc_dp.sv @@
// reader frame codec datapath: frame byte builder, reply store and checker,
// output register; depends on rfc_pkg, driven by rfc_ctrl commands
module rfc_dp #(
  parameter int unsigned ReplyDepth = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rfc_pkg::cmd_t              cmd_i,
  output rfc_pkg::sts_t              sts_o,
  input  logic                       in_cmd_i,
  input  logic                       in_final_i,
  input  logic [rfc_pkg::AddrW-1:0]  in_addr_i,
  input  logic [rfc_pkg::ByteW-1:0]  in_func_i,
  input  logic [rfc_pkg::ByteW-1:0]  in_data_i,
  input  logic [rfc_pkg::ByteW-1:0]  in_rx_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [rfc_pkg::KindW-1:0]  out_kind_o,
  output logic [rfc_pkg::ByteW-1:0]  out_byte_o,
  output logic [rfc_pkg::StatW-1:0]  out_status_o,
  output logic [rfc_pkg::PayCntW-1:0] out_count_o,
  output logic                       out_last_o
);
  import rfc_pkg::*;

  localparam int unsigned AW = $clog2(ReplyDepth);
  localparam int unsigned KW = $clog2(ReplyDepth + 1);
  localparam int unsigned NW = KW + 1;

  // request fields held for the frame
  logic [3:0]       at_q, ao_q, dh_q, dt_q, dd_q;
  logic [ByteW-1:0] func_q, data_q, fx_q;
  logic             raw_q;
  logic [1:0]       ndig_q;
  logic [StepW-1:0] step_q;

  // reply state
  logic [ByteW-1:0] store [ReplyDepth];
  logic [KW-1:0]    kept_q;
  logic [ByteW-1:0] rxor_q;
  logic             ovf_q;
  logic [AW-1:0]    rd_idx_q, pay_end_q;
  logic [ByteW-1:0] rd_data_q;
  logic [StatW-1:0] stat_q;
  logic [PayCntW-1:0] cnt_q;

  // output register
  logic               ov_q, last_q;
  logic [KindW-1:0]   kind_q;
  logic [ByteW-1:0]   byte_q;
  logic [StatW-1:0]   ost_q;
  logic [PayCntW-1:0] ocnt_q;

  logic               send_take, rx_take, rx_drop, rx_full;
  dec_t               adec, ddec;
  logic [ByteW-1:0]   addr_mod;
  logic [ByteW-1:0]   fbyte, dbyte;
  logic [StepW-1:0]   last_step, dstep;
  logic [NW-1:0]      n_w;
  logic               ovf_w;
  logic [StatW-1:0]   stat_w;
  logic [PayCntW-1:0] cnt_w;

  assign send_take = cmd_i.take && (in_cmd_i == CMD_SEND);
  assign rx_take   = cmd_i.take && (in_cmd_i == CMD_RECV);
  assign rx_drop   = (kept_q == '0) && (in_rx_i == '0);
  assign rx_full   = (kept_q >= KW'(ReplyDepth));

  // decimal digits of address and data
  always_comb begin
    addr_mod = (in_addr_i >= 7'd100) ? {1'b0, in_addr_i - 7'd100} : {1'b0, in_addr_i};
    adec     = dec3(addr_mod);
    ddec     = dec3(in_data_i);
  end

  // reply check at the final byte
  always_comb begin
    n_w   = rx_drop ? '0 : NW'(kept_q) + NW'(1);
    ovf_w = ovf_q || (!rx_drop && rx_full);
    if (ovf_w)                                stat_w = ST_OVERFLOW;
    else if (n_w < NW'(3))                    stat_w = ST_SHORT;
    else if (in_rx_i != (rxor_q | SUM_MARK))  stat_w = ST_BAD_SUM;
    else                                      stat_w = ST_OK;
    if (stat_w == ST_OK && n_w > NW'(PayOver)) cnt_w = PayCntW'(n_w - NW'(PayOver));
    else                                       cnt_w = '0;
  end

  // frame byte at the current step
  always_comb begin
    dstep     = step_q - STEP_D0;
    last_step = STEP_D1 + {2'd0, ndig_q};
    if (raw_q) begin
      dbyte = data_q;
    end else begin
      case (ndig_q)
        2'd3:    dbyte = CH_ZERO + {4'd0, (dstep == 4'd0) ? dh_q : (dstep == 4'd1) ? dt_q : dd_q};
        2'd2:    dbyte = CH_ZERO + {4'd0, (dstep == 4'd0) ? dt_q : dd_q};
        default: dbyte = CH_ZERO + {4'd0, dd_q};
      endcase
    end
    if (step_q == last_step)                fbyte = fx_q | SUM_MARK;
    else if (step_q == last_step - 4'd1)    fbyte = CH_ETX;
    else begin
      case (step_q)
        STEP_SOH: fbyte = CH_SOH;
        STEP_S:   fbyte = CH_S;
        STEP_AT:  fbyte = CH_ZERO + {4'd0, at_q};
        STEP_AO:  fbyte = CH_ZERO + {4'd0, ao_q};
        STEP_FH:  fbyte = hex_char(func_q[7:4]);
        STEP_FL:  fbyte = hex_char(func_q[3:0]);
        STEP_STX: fbyte = CH_STX;
        default:  fbyte = dbyte;
      endcase
    end
  end

  assign sts_o.out_free   = !ov_q || out_ready_i;
  assign sts_o.frame_last = (step_q == last_step);
  assign sts_o.has_pay    = (cnt_q != '0);
  assign sts_o.pay_last   = (rd_idx_q == pay_end_q);

  // request capture and frame walk
  always_ff @(posedge clk_i) begin
    if (send_take) begin
      at_q   <= adec.tens;
      ao_q   <= adec.ones;
      dh_q   <= ddec.hund;
      dt_q   <= ddec.tens;
      dd_q   <= ddec.ones;
      func_q <= in_func_i;
      data_q <= in_data_i;
      raw_q  <= (in_func_i == FUNC_RAW);
      if (in_func_i == FUNC_RAW || in_data_i < 8'd10) ndig_q <= 2'd1;
      else if (in_data_i < 8'd100)                     ndig_q <= 2'd2;
      else                                             ndig_q <= 2'd3;
      step_q <= STEP_SOH;
      fx_q   <= '0;
    end else if (cmd_i.emit_frame) begin
      step_q <= step_q + 4'd1;
      fx_q   <= fx_q ^ fbyte;
    end
  end

  // reply store write and payload read
  always_ff @(posedge clk_i) begin
    if (rx_take && !in_final_i && !rx_drop && !rx_full) begin
      store[kept_q[AW-1:0]] <= in_rx_i;
    end
    if (cmd_i.rd_req) begin
      rd_data_q <= store[rd_idx_q];
    end
    if (rx_take && in_final_i) begin
      stat_q    <= stat_w;
      cnt_q     <= cnt_w;
      pay_end_q <= AW'(kept_q - KW'(2));
    end
    if (cmd_i.pay_start)     rd_idx_q <= AW'(PayFirst);
    else if (cmd_i.emit_pay) rd_idx_q <= rd_idx_q + AW'(1);
  end

  // reply receive state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q <= '0;
      rxor_q <= '0;
      ovf_q  <= 1'b0;
    end else if (send_take || (rx_take && in_final_i)) begin
      kept_q <= '0;
      rxor_q <= '0;
      ovf_q  <= 1'b0;
    end else if (rx_take && !rx_drop) begin
      if (rx_full) begin
        ovf_q <= 1'b1;
      end else begin
        kept_q <= kept_q + KW'(1);
        rxor_q <= rxor_q ^ in_rx_i;
      end
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit_frame || cmd_i.emit_pay || cmd_i.emit_stat) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_frame) begin
      kind_q <= KIND_FRAME;
      byte_q <= fbyte;
      ost_q  <= ST_OK;
      ocnt_q <= '0;
      last_q <= sts_o.frame_last;
    end else if (cmd_i.emit_pay) begin
      kind_q <= KIND_PAY;
      byte_q <= rd_data_q;
      ost_q  <= ST_OK;
      ocnt_q <= '0;
      last_q <= 1'b0;
    end else if (cmd_i.emit_stat) begin
      kind_q <= KIND_STATUS;
      byte_q <= '0;
      ost_q  <= stat_q;
      ocnt_q <= cnt_q;
      last_q <= 1'b1;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_kind_o   = kind_q;
  assign out_byte_o   = byte_q;
  assign out_status_o = ost_q;
  assign out_count_o  = ocnt_q;
  assign out_last_o   = last_q;

endmodule

@@ src/reader_frame_codec_top.sv @@
// reader frame codec top level: stream ports around controller and datapath
// depends on rfc_pkg, rfc_ctrl and rfc_dp
//
// A send word (tuser 0) emits a request frame of 10 to 12 bytes, one per
// cycle while the output is taken; reply bytes (tuser 1) are stored, and
// the final one (tlast) is checked and followed by the payload read from
// the reply store, each byte taking one memory read and then one output load,
// and a status word. Input is taken only while no frame or readout is in
// progress; a finished word may wait in the output register.
module reader_frame_codec_top #(
  parameter int unsigned ReplyDepth = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // dev_address[6:0], function_code[14:7], request_data[22:15], rx_byte[30:23]
  input  logic [31:0] s_axis_tdata,
  // command
  input  logic        s_axis_tuser,
  // rx_final
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // byte_out[7:0], status[9:8], payload_count[16:10]
  output logic [23:0] m_axis_tdata,
  // kind
  output logic [1:0]  m_axis_tuser,
  // last
  output logic        m_axis_tlast
);
  import rfc_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [ByteW-1:0]   out_byte;
  logic [StatW-1:0]   out_status;
  logic [PayCntW-1:0] out_count;

  // sequencer
  rfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_final_i (s_axis_tlast),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready)
  );

  // frame builder and reply checker
  rfc_dp #(
    .ReplyDepth (ReplyDepth)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_cmd_i     (s_axis_tuser),
    .in_final_i   (s_axis_tlast),
    .in_addr_i    (s_axis_tdata[6:0]),
    .in_func_i    (s_axis_tdata[14:7]),
    .in_data_i    (s_axis_tdata[22:15]),
    .in_rx_i      (s_axis_tdata[30:23]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_kind_o   (m_axis_tuser),
    .out_byte_o   (out_byte),
    .out_status_o (out_status),
    .out_count_o  (out_count),
    .out_last_o   (m_axis_tlast)
  );

  // output word packing
  assign m_axis_tdata = {7'd0, out_count, out_status, out_byte};

endmodule

@@ bench/tb_reader_frame_codec_top.sv @@
// testbench for the reader frame codec top level: request framing and reply checking
// depends on rfc_pkg and reader_frame_codec_top
module tb_reader_frame_codec_top;
  import rfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 64;

  typedef struct packed {
    logic       cmd;
    logic [6:0] addr;
    logic [7:0] func;
    logic [7:0] data;
    logic [7:0] rx;
    logic       fin;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_v;
    logic [1:0] stat;
    logic [6:0] cnt;
    logic       last;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  reader_frame_codec_top #(.ReplyDepth(Depth)) dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0] reply_mem [Depth];
  int unsigned kept;
  logic [7:0]  kept_xor;
  logic        ovf;

  req_t pending_q[$];
  res_t expected_q[$];
  int   errors = 0;
  bit   calm = 0;
  bit   in_taken = 0;
  int   rx_cycles = 0;

  function automatic logic [7:0] hex_ch(input logic [3:0] v);
    return (v < 10) ? 8'(8'h30 + v) : 8'(8'h41 + (v - 10));
  endfunction

  function automatic res_t mk(input logic [1:0] k, input logic [7:0] b,
                              input logic [1:0] s, input logic [6:0] c,
                              input logic l);
    res_t r;
    r.kind = k; r.byte_v = b; r.stat = s; r.cnt = c; r.last = l;
    return r;
  endfunction

  // work out the words caused by one accepted request
  task automatic predict_codec(input req_t q);
    logic [7:0]  fr [$];
    logic [7:0]  x;
    int unsigned a, n, cnt;
    logic [1:0]  st;
    x = 0;
    if (q.cmd == CMD_SEND) begin
      kept = 0; kept_xor = 0; ovf = 0;
      a = q.addr % 100;
      fr = '{CH_SOH, CH_S, 8'(8'h30 + a / 10), 8'(8'h30 + a % 10),
             hex_ch(q.func[7:4]), hex_ch(q.func[3:0]), CH_STX};
      if (q.func == FUNC_RAW) fr.push_back(q.data);
      else begin
        if (q.data >= 100) fr.push_back(8'(8'h30 + q.data / 100));
        if (q.data >= 10) fr.push_back(8'(8'h30 + (q.data / 10) % 10));
        fr.push_back(8'(8'h30 + q.data % 10));
      end
      fr.push_back(CH_ETX);
      foreach (fr[i]) x ^= fr[i];
      fr.push_back(x | SUM_MARK);
      foreach (fr[i])
        expected_q.push_back(mk(KIND_FRAME, fr[i], ST_OK, 7'd0, i == fr.size() - 1));
    end else if (q.fin) begin
      if (kept == 0 && q.rx == 0) n = 0;
      else begin
        if (kept >= Depth) ovf = 1;
        n = kept + 1;
      end
      if (ovf) st = ST_OVERFLOW;
      else if (n < 3) st = ST_SHORT;
      else if (q.rx != (kept_xor | SUM_MARK)) st = ST_BAD_SUM;
      else st = ST_OK;
      cnt = 0;
      if (st == ST_OK) begin
        cnt = n > 9 ? n - 9 : 0;
        for (int i = 0; i < cnt; i++)
          expected_q.push_back(mk(KIND_PAY, reply_mem[7 + i], ST_OK, 7'd0, 1'b0));
      end
      expected_q.push_back(mk(KIND_STATUS, 8'd0, st, 7'(cnt), 1'b1));
      kept = 0; kept_xor = 0; ovf = 0;
    end else if (!(kept == 0 && q.rx == 0)) begin
      if (kept >= Depth) ovf = 1;
      else begin
        reply_mem[kept] = q.rx;
        kept++;
        kept_xor ^= q.rx;
      end
    end
  endtask

  function automatic req_t send_req(input int a, input int f, input int d);
    req_t q;
    q = '0; q.cmd = CMD_SEND; q.addr = 7'(a); q.func = 8'(f); q.data = 8'(d);
    q.rx = 8'($urandom); q.fin = 1'($urandom);
    return q;
  endfunction

  function automatic req_t rx_req(input logic [7:0] b, input logic f);
    req_t q;
    q = '0; q.cmd = CMD_RECV; q.rx = b; q.fin = f;
    q.addr = 7'($urandom); q.func = 8'($urandom); q.data = 8'($urandom);
    return q;
  endfunction

  // queue a reply of len kept bytes with random content; good checksum unless broken
  task automatic push_reply(input int len, input bit lead0, input bit bad);
    logic [7:0] x, b;
    x = 0;
    if (lead0) repeat ($urandom_range(1, 3)) pending_q.push_back(rx_req(8'd0, 1'b0));
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == 0 && b == 0) b = 8'h5A;
      x ^= b;
      pending_q.push_back(rx_req(b, 1'b0));
    end
    b = x | SUM_MARK;
    if (bad) b = b ^ 8'h01;
    pending_q.push_back(rx_req(b, 1'b1));
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        in_taken = 1'b0;
        if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= 17)) begin
          req_t q;
          q = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= q.cmd;
          s_axis_tlast <= q.fin;
          s_axis_tdata <= {1'b0, q.rx, q.data, q.func, q.addr};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long stall early in the run
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_cycles <= rx_cycles + 1;
      if (rx_cycles >= 20 && rx_cycles < 320) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 17);
      end
    end
  end

  // input acceptance feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      req_t q;
      q.cmd = s_axis_tuser; q.fin = s_axis_tlast;
      q.addr = s_axis_tdata[6:0]; q.func = s_axis_tdata[14:7];
      q.data = s_axis_tdata[22:15]; q.rx = s_axis_tdata[30:23];
      predict_codec(q);
      in_taken = 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      res_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected word kind=%0d data=%h", m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tuser != e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, m_axis_tuser); errors++;
        end
        if (m_axis_tdata[7:0] != e.byte_v) begin
          $error("byte_out: expected %h actual %h", e.byte_v, m_axis_tdata[7:0]); errors++;
        end
        if (m_axis_tdata[9:8] != e.stat) begin
          $error("status: expected %0d actual %0d", e.stat, m_axis_tdata[9:8]); errors++;
        end
        if (m_axis_tdata[16:10] != e.cnt) begin
          $error("payload_count: expected %0d actual %0d", e.cnt, m_axis_tdata[16:10]);
          errors++;
        end
        if (m_axis_tdata[23:17] != 0) begin
          $error("pad: expected 0 actual %h", m_axis_tdata[23:17]); errors++;
        end
        if (m_axis_tlast != e.last) begin
          $error("last: expected %0d actual %0d", e.last, m_axis_tlast); errors++;
        end
      end
    end
  end

  // timeout
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int r;
    kept = 0; kept_xor = 0; ovf = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: field extremes, raw data, digit counts, address wrap
    pending_q.push_back(send_req(0, 0, 0));
    pending_q.push_back(send_req(99, 8'hFF, 0));
    pending_q.push_back(send_req(127, 8'hFF, 255));
    pending_q.push_back(send_req(100, 8'hA5, 9));
    pending_q.push_back(send_req(42, 8'h5A, 10));
    pending_q.push_back(send_req(7, 8'hFE, 255));
    pending_q.push_back(send_req(55, 8'h10, 100));
    // zero final alone, short reply, bad sum, no payload, payload, overflow
    pending_q.push_back(rx_req(8'd0, 1'b1));
    push_reply(1, 1, 0);
    push_reply(5, 0, 1);
    push_reply(8, 1, 0);
    push_reply(12, 0, 0);
    push_reply(Depth + 2, 0, 0);
    push_reply(Depth - 1, 0, 0);
    // send in the middle of a reply
    pending_q.push_back(rx_req(8'h33, 1'b0));
    pending_q.push_back(rx_req(8'hFF, 1'b0));
    pending_q.push_back(send_req(1, 2, 3));
    pending_q.push_back(rx_req(8'h00, 1'b1));

    // more words queued while the receiver stalls
    pending_q.push_back(send_req(11, 8'h22, 33));
    pending_q.push_back(send_req(12, 8'h23, 34));
    push_reply(20, 0, 0);

    // random part
    for (int i = 0; i < 30; i++) begin
      r = $urandom_range(0, 99);
      if (i >= 12 && i < 20) calm = 1;
      else calm = 0;
      if (r < 35) pending_q.push_back(send_req($urandom_range(0, 127),
                                               $urandom_range(0, 3) == 0 ? 255 : $urandom,
                                               $urandom));
      else if (r < 90) push_reply($urandom_range(0, 14), $urandom_range(0, 3) == 0,
                                  $urandom_range(0, 4) == 0);
      else pending_q.push_back(rx_req(8'($urandom), 1'($urandom)));
      while (pending_q.size() > 8) @(posedge clk_i);
    end
    calm = 0;
    while (pending_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

@@ reader_frame_codec_top.f @@
src/rfc_pkg.sv
src/rfc_ctrl.sv
src/rfc_dp.sv
src/reader_frame_codec_top.sv
bench/tb_reader_frame_codec_top.sv
